>>> hdl/two_stack_queue_top_macros.svh
// Assertion macros for the two-stack queue.
// Included by the top level; depends on nothing else.
`ifndef TWO_STACK_QUEUE_TOP_MACROS_SVH
`define TWO_STACK_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TSQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Delayed implication, disabled while reset is asserted
`define TSQ_ASSERT_LATER2(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

>>> hdl/tsq_pkg.sv
// Shared types and codes of the two-stack queue.
// Used by the controller, the datapath and the top level; no dependencies.
package tsq_pkg;

    // Command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic       latch;      // capture the incoming value
        logic       push;       // write inbox top, bump inbox count
        logic       push_src;   // 1: push the port value, 0: the captured one
        logic       pour_rd;    // read inbox top, drop inbox count
        logic       pop_rd;     // read outbox top, drop outbox count
        logic       res_load;   // load the result registers
        logic [1:0] res_status;
        logic       res_pop;    // result carries the popped value
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic ic_full;
        logic ic_zero;
        logic oc_zero;
        logic pend;             // an inbox read is on its way to the outbox
    } t_dp_stat;

endpackage

>>> hdl/tsq_datapath.sv
// Datapath of the two-stack queue: inbox and outbox memories, counts,
// pour pipeline and result registers. Depends on tsq_pkg.
module tsq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic signed [31:0]  i_value_in,
    input  tsq_pkg::t_dp_cmd    i_cmd,
    output tsq_pkg::t_dp_stat   o_stat,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_value_out,
    output logic [5:0]          o_occupancy
);
    import tsq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = (CW + 1 > 6) ? CW + 1 : 6;

    logic [31:0]   r_inbox  [DEPTH];
    logic [31:0]   r_outbox [DEPTH];
    logic [CW-1:0] r_ic, n_ic;
    logic [CW-1:0] r_oc, n_oc;
    logic          r_pend;
    logic [31:0]   r_in_rd;
    logic [31:0]   r_out_rd;
    logic [31:0]   r_value;
    logic          r_valid;
    logic [1:0]    r_status;
    logic [31:0]   r_res_value;
    logic [5:0]    r_occ;

    logic [CW-1:0] w_ic_dec;
    logic [CW-1:0] w_oc_dec;
    logic [31:0]   w_push_data;
    logic [SW-1:0] w_sum;

    assign w_ic_dec    = r_ic - CW'(1);
    assign w_oc_dec    = r_oc - CW'(1);
    assign w_push_data = i_cmd.push_src ? i_value_in : r_value;
    assign w_sum       = SW'(r_ic) + SW'(r_oc);

    // Report count conditions to the controller
    assign o_stat.ic_full = (r_ic == CW'(DEPTH));
    assign o_stat.ic_zero = (r_ic == '0);
    assign o_stat.oc_zero = (r_oc == '0);
    assign o_stat.pend    = r_pend;

    // Advance counts: inbox grows on push and shrinks on pour reads,
    // outbox grows on pour writes and shrinks on pops
    always_comb begin
        n_ic = r_ic;
        n_oc = r_oc;
        if (i_cmd.push) begin
            n_ic = r_ic + CW'(1);
        end else if (i_cmd.pour_rd) begin
            n_ic = w_ic_dec;
        end
        if (r_pend) begin
            n_oc = r_oc + CW'(1);
        end else if (i_cmd.pop_rd) begin
            n_oc = w_oc_dec;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic    <= '0;
            r_oc    <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_ic    <= n_ic;
            r_oc    <= n_oc;
            r_pend  <= i_cmd.pour_rd;
            r_valid <= i_cmd.res_load;
        end
    end

    // Inbox memory: one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_inbox[r_ic[AW-1:0]] <= w_push_data;
        end
        if (i_cmd.pour_rd) begin
            r_in_rd <= r_inbox[w_ic_dec[AW-1:0]];
        end
    end

    // Outbox memory: pour writes land on top, pops read the top
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_outbox[r_oc[AW-1:0]] <= r_in_rd;
        end
        if (i_cmd.pop_rd) begin
            r_out_rd <= r_outbox[w_oc_dec[AW-1:0]];
        end
    end

    // Hold the accepted value and the result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_value <= i_value_in;
        end
        if (i_cmd.res_load) begin
            r_status    <= i_cmd.res_status;
            r_res_value <= i_cmd.res_pop ? r_out_rd : '0;
            r_occ       <= w_sum[5:0];
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_out = r_res_value;
    assign o_occupancy = r_occ;

endmodule

>>> hdl/tsq_ctrl.sv
// Controller of the two-stack queue: sequences push, pour and pop.
// Depends on tsq_pkg; drives tsq_datapath through command signals.
module tsq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               i_cmd,
    input  tsq_pkg::t_dp_stat  i_stat,
    output logic               busy,
    output tsq_pkg::t_dp_cmd   o_cmd
);
    import tsq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POUR = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_op, n_op;
    logic [1:0] r_status, n_status;

    assign busy = (r_state != S_IDLE);

    // Decode the command and step through the pour
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_op        = i_cmd;
                    n_status    = ST_DONE;
                    n_state     = S_DONE;
                    if (i_cmd == CMD_ENQ) begin
                        if (!i_stat.ic_full) begin
                            o_cmd.push     = 1'b1;
                            o_cmd.push_src = 1'b1;
                        end else if (i_stat.oc_zero) begin
                            n_state = S_POUR;
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else begin
                        if (i_stat.ic_zero && i_stat.oc_zero) begin
                            n_status = ST_EMPTY;
                        end else if (i_stat.oc_zero) begin
                            n_state = S_POUR;
                        end else begin
                            o_cmd.pop_rd = 1'b1;
                        end
                    end
                end
            end
            S_POUR: begin
                o_cmd.pour_rd = !i_stat.ic_zero;
                // Finish the command once the last item has landed
                if (i_stat.ic_zero && !i_stat.pend) begin
                    if (r_op == CMD_ENQ) begin
                        o_cmd.push = 1'b1;
                    end else begin
                        o_cmd.pop_rd = 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = r_status;
                o_cmd.res_pop    = (r_op == CMD_DEQ) && (r_status == ST_DONE);
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= CMD_ENQ;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_status <= n_status;
        end
    end

endmodule

>>> hdl/two_stack_queue_top.sv
// Two-stack FIFO queue of signed 32-bit values, DEPTH entries per stack.
// A command is taken when start is high and busy is low. An enqueue, a
// dequeue served from a non-empty outbox, a rejected enqueue and a dequeue
// on an empty queue go from idle to S_DONE and back to idle. When the
// outbox must be refilled, the n items of the inbox are moved first, one per
// cycle through the inbox read port and its read register, before the
// command ends in S_DONE. The result shows on the o_ ports for exactly
// one cycle with o_valid high, in the cycle busy drops; the receiver cannot
// stall it and must take it then. Depends on tsq_pkg, tsq_ctrl,
// tsq_datapath and the assertion macro header.
`include "two_stack_queue_top_macros.svh"

module two_stack_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               i_cmd,
    input  logic signed [31:0] i_value_in,
    output logic               busy,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_value_out,
    output logic [5:0]         o_occupancy
);
    import tsq_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequence each command
    tsq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_stat  (w_stat),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // Hold both stacks and the result
    tsq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value_in  (i_value_in),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_occupancy (o_occupancy)
    );

    // A command without a refill answers once S_DONE has loaded the result
    `TSQ_ASSERT_LATER2(a_quick_result, i_clk, i_rst_n, start && !busy && !(i_cmd == CMD_ENQ && w_stat.ic_full && w_stat.oc_zero) && !(i_cmd == CMD_DEQ && w_stat.oc_zero && !w_stat.ic_zero), o_valid, "result missing two cycles after a direct command")

    // A result strobe lasts one cycle
    `TSQ_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held over two cycles")

    // A result appears only once the block is ready again
    `TSQ_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy, "result strobe while busy")

    // Failed commands return zero data
    `TSQ_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_valid && (o_status != ST_DONE), o_value_out == '0, "nonzero value on a failed command")

endmodule

>>> bench/two_stack_queue_top_tb.sv
// Self-checking bench for the two-stack queue: directed corner cases, then
// random enqueue/dequeue traffic at three sender idle rates, checked against
// an in-bench queue predictor. Depends on tsq_pkg and two_stack_queue_top.
`timescale 1ns / 1ps

module two_stack_queue_top_tb;
    import tsq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int STALL_MAX  = 2000;   // cycles with no item in or out
    localparam int DRAIN_WAIT = 40;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic [5:0]         occupancy;
    } queue_result_t;

    logic               i_clk;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic               i_cmd      = CMD_ENQ;
    logic signed [31:0] i_value_in = '0;
    logic               busy;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_value_out;
    logic [5:0]         o_occupancy;

    // Predictor state: the two stacks as the block should hold them
    logic signed [31:0] inbox_mem [DEPTH];
    logic signed [31:0] outbox_mem[DEPTH];
    int                 inbox_cnt  = 0;
    int                 outbox_cnt = 0;

    queue_result_t      results_due[$];
    int                 error_count     = 0;
    int                 sender_idle_pct = 0;
    int                 stall_cycles    = 0;

    two_stack_queue_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd      (i_cmd),
        .i_value_in (i_value_in),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_value_out(o_value_out),
        .o_occupancy(o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Move the whole inbox onto the outbox, top of inbox first
    function automatic void pour_inbox();
        while (inbox_cnt > 0 && outbox_cnt < DEPTH) begin
            inbox_cnt--;
            outbox_mem[outbox_cnt] = inbox_mem[inbox_cnt];
            outbox_cnt++;
        end
    endfunction

    // Advance the queue model by one command and queue its result
    function automatic void predict_command(logic cmd, logic signed [31:0] value);
        queue_result_t res;
        res.status = ST_DONE;
        res.value  = '0;
        if (cmd == CMD_ENQ) begin
            if (inbox_cnt >= DEPTH) begin
                if (outbox_cnt == 0)
                    pour_inbox();
                else
                    res.status = ST_FULL;
            end
            if (res.status == ST_DONE && inbox_cnt < DEPTH) begin
                inbox_mem[inbox_cnt] = value;
                inbox_cnt++;
            end
        end else begin
            if (inbox_cnt == 0 && outbox_cnt == 0) begin
                res.status = ST_EMPTY;
            end else begin
                if (outbox_cnt == 0)
                    pour_inbox();
                outbox_cnt--;
                res.value = outbox_mem[outbox_cnt];
            end
        end
        res.occupancy = 6'(inbox_cnt + outbox_cnt);
        results_due.push_back(res);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Send one item: idle at random first, then hold start until accepted.
    // Start is left high so a back-to-back item needs no second assignment.
    task automatic send_command(logic cmd, logic signed [31:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_value_in <= value;
        do @(posedge i_clk); while (busy);
        predict_command(cmd, value);
    endtask

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        queue_result_t want;
        if (i_rst_n && o_valid) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result status", 32'(o_status), 32'hx);
            end else begin
                want = results_due.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_value_out !== want.value)
                    report_mismatch("value_out", o_value_out, want.value);
                if (o_occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(o_occupancy), 32'(want.occupancy));
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic test_empty_dequeue();
        send_command(CMD_DEQ, $urandom);
    endtask

    // Fill the inbox with extreme values, then enqueue into a full inbox
    // with an empty outbox so the inbox is poured first
    task automatic test_fill_and_pour();
        send_command(CMD_ENQ, 32'sh8000_0000);
        send_command(CMD_ENQ, 32'sh7FFF_FFFF);
        send_command(CMD_ENQ, 32'sh0000_0000);
        send_command(CMD_ENQ, -32'sd1);
        send_command(CMD_ENQ, 32'sh0000_0001);
        send_command(CMD_ENQ, 32'shAAAA_AAAA);
        send_command(CMD_ENQ, 32'sh5555_5555);
        repeat (DEPTH - 7) send_command(CMD_ENQ, $urandom);
        send_command(CMD_ENQ, $urandom);
    endtask

    // Refill the inbox while the outbox holds items: the next enqueue is rejected
    task automatic test_full_reject();
        repeat (DEPTH - 1) send_command(CMD_ENQ, $urandom);
        send_command(CMD_ENQ, $urandom);
    endtask

    // Drain the outbox, then dequeue with only the inbox holding items,
    // then dequeue once more on an empty queue
    task automatic test_drain_and_refill();
        while (outbox_cnt > 0) send_command(CMD_DEQ, $urandom);
        repeat (DEPTH + 1) send_command(CMD_DEQ, $urandom);
    endtask

    // Random traffic in bursts, each with its own enqueue bias to sweep fill levels
    task automatic test_random_traffic(int items, int idle_pct);
        int sent;
        int burst;
        int enq_pct;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < items) begin
            burst   = $urandom_range(60, 10);
            enq_pct = $urandom_range(85, 15);
            repeat (burst) begin
                send_command(($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ, $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 29;
        test_empty_dequeue();
        test_fill_and_pour();
        test_full_reject();
        test_drain_and_refill();
        test_random_traffic(400, 29);
        test_random_traffic(400, 86);
        test_random_traffic(400, 0);
        start <= 1'b0;

        // Wait out the last results, then a few more cycles
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
